// ----- rtl/wps_pkg.sv -----
// shared types and constants for the windowed prefix servability block
package wps_pkg;

    localparam int MAX_GROUPS   = 8;
    localparam int BITS_W       = 32;
    localparam int WIN_W        = 11;
    localparam int LEN_W        = 11;
    localparam int NUM_WIN_REGS = 4;
    localparam int IDX_W        = 2;

    typedef logic [WIN_W-1:0] win_t;
    typedef logic [IDX_W-1:0] reg_idx_t;

    // classified chunk handed from front to back
    typedef struct packed {
        logic [MAX_GROUPS-1:0] present;
        logic                  last;
    } chunk_class_t;

    // one result request
    typedef struct packed {
        logic             servable;
        logic [LEN_W-1:0] prefix_length;
    } result_t;

endpackage

// ----- rtl/wps_fifo.sv -----
// small first-in first-out queue used between the stages
module wps_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/wps_front.sv -----
// front stage: reduces the found bits of a chunk to one present flag per group
module wps_front #(
    parameter int GROUP_COUNT = 4,
    parameter int RANK_COUNT  = 8
) (
    input  logic [wps_pkg::BITS_W-1:0] chunk_bits,
    input  logic                       last_chunk,
    output wps_pkg::chunk_class_t      chunk_class
);

    import wps_pkg::*;

    logic [MAX_GROUPS-1:0] present;

    for (genvar g = 0; g < MAX_GROUPS; g++)
    begin : g_group
        if (g < GROUP_COUNT)
        begin : g_used
            logic [RANK_COUNT-1:0] found;
            for (genvar r = 0; r < RANK_COUNT; r++)
            begin : g_rank
                localparam int IDX = g * RANK_COUNT + r;
                if (IDX < BITS_W)
                begin : g_in
                    assign found[r] = chunk_bits[IDX];
                end
                else
                begin : g_out
                    // cell beyond the bit field never counts as found
                    assign found[r] = 1'b0;
                end
            end
            assign present[g] = &found;
        end
        else
        begin : g_unused
            assign present[g] = 1'b0;
        end
    end

    assign chunk_class.present = present;
    assign chunk_class.last    = last_chunk;

endmodule

// ----- rtl/wps_back.sv -----
// back stage: run counters, prefix length, window compare and window registers
module wps_back #(
    parameter int GROUP_COUNT = 4,
    parameter int MAX_CHUNKS  = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  wps_pkg::reg_idx_t         wr_index,
    input  wps_pkg::win_t             wr_data,
    input  logic                      in_empty,
    input  wps_pkg::chunk_class_t     in_item,
    output logic                      in_pop,
    input  logic                      out_full,
    output logic                      out_push,
    output wps_pkg::result_t          out_item
);

    import wps_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHUNKS);

    win_t             win_reg [NUM_WIN_REGS];
    logic [CNT_W-1:0] run_reg [GROUP_COUNT];
    logic [CNT_W-1:0] run_next [GROUP_COUNT];
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0] plen;
    logic [CMP_W-1:0] plen_ext;
    logic [GROUP_COUNT-1:0] ok_grp;
    logic             fire;

    assign fire     = !in_empty && !out_full;
    assign in_pop   = fire;
    assign out_push = fire;

    // prefix length including this chunk, held at the ceiling
    assign plen     = (seen_reg == MAX_CNT) ? MAX_CNT : seen_reg + CNT_W'(1);
    assign plen_ext = CMP_W'(plen);

    for (genvar g = 0; g < GROUP_COUNT; g++)
    begin : g_group
        logic [CMP_W-1:0] win;
        logic [CMP_W-1:0] need;
        logic [CNT_W-1:0] run_upd;

        if (g < NUM_WIN_REGS)
        begin : g_reg
            assign win = CMP_W'(win_reg[g]);
        end
        else
        begin : g_whole
            assign win = '0;
        end

        always_comb
        begin
            if (in_item.present[g])
            begin
                run_upd = (run_reg[g] == MAX_CNT) ? run_reg[g] : run_reg[g] + CNT_W'(1);
            end
            else
            begin
                run_upd = '0;
            end
            // zero or oversized window means the whole prefix
            need      = ((win == '0) || (win > plen_ext)) ? plen_ext : win;
            ok_grp[g] = (CMP_W'(run_upd) >= need);
            if (fire)
            begin
                run_next[g] = in_item.last ? '0 : run_upd;
            end
            else
            begin
                run_next[g] = run_reg[g];
            end
        end
    end

    always_comb
    begin
        if (fire)
        begin
            seen_next = in_item.last ? '0 : plen;
        end
        else
        begin
            seen_next = seen_reg;
        end
        out_item.servable      = &ok_grp;
        out_item.prefix_length = plen_ext[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                run_reg[g] <= '0;
            end
            for (int i = 0; i < NUM_WIN_REGS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            seen_reg <= seen_next;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                run_reg[g] <= run_next[g];
            end
            if (wr_en)
            begin
                win_reg[wr_index] <= wr_data;
            end
        end
    end

endmodule

// ----- rtl/windowed_prefix_servability.sv -----
// top level of the windowed prefix servability block
//
// takes one cache chunk per request, a found bit for each (group, rank) cell,
// and returns one result per chunk: whether the prefix ending at that chunk
// can be served by every group, and the prefix length in chunks (saturating
// at MAX_CHUNKS). a group holds a chunk only when all its ranks are found;
// each group keeps a run of consecutive held chunks and must cover
// min(window, prefix length), window 0 meaning the whole prefix. a request
// with last_chunk set closes the query and clears runs and length after its
// result. throughput is one chunk per clock while results are popped; a
// result reaches the result ports once the classify queue has registered
// its chunk and the counter stage then writes its result straight into the
// result queue. both queues are two deep, so either side can stall on its
// own. window registers are written through wr_en/wr_index/wr_data; the
// user must do so only while the block is idle; the block does not check
module windowed_prefix_servability #(
    parameter int GROUP_COUNT = 4,
    parameter int RANK_COUNT  = 8,
    parameter int MAX_CHUNKS  = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // chunk request side
    input  logic                       push,
    output logic                       full,
    input  logic [wps_pkg::BITS_W-1:0] chunk_bits,
    input  logic                       last_chunk,
    // result side
    output logic                       empty,
    input  logic                       pop,
    output logic                       servable,
    output logic [wps_pkg::LEN_W-1:0]  prefix_length,
    // window register writes
    input  logic                       wr_en,
    input  wps_pkg::reg_idx_t          wr_index,
    input  wps_pkg::win_t              wr_data
);

    import wps_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    chunk_class_t front_class;
    chunk_class_t mid_item;
    logic         mid_empty;
    logic         mid_pop;
    result_t      back_result;
    result_t      out_item;
    logic         out_full;
    logic         out_push;

    // group presence from the raw found bits
    wps_front #(
        .GROUP_COUNT (GROUP_COUNT),
        .RANK_COUNT  (RANK_COUNT)
    ) u_front (
        .chunk_bits  (chunk_bits),
        .last_chunk  (last_chunk),
        .chunk_class (front_class)
    );

    // decouples classification from the counter stage
    wps_fifo #(
        .WIDTH ($bits(chunk_class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_class),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_item),
        .empty (mid_empty)
    );

    // run counters, prefix length and window compare
    wps_back #(
        .GROUP_COUNT (GROUP_COUNT),
        .MAX_CHUNKS  (MAX_CHUNKS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_empty (mid_empty),
        .in_item  (mid_item),
        .in_pop   (mid_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_item (back_result)
    );

    // finished results wait here until popped
    wps_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_result),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_item),
        .empty (empty)
    );

    assign servable      = out_item.servable;
    assign prefix_length = out_item.prefix_length;

endmodule
